// File: src/stfd_pkg.sv
package stfd_pkg;

   localparam int VAL_W  = 32;
   localparam int POS_W  = 5;
   localparam int STAT_W = 2;
   localparam int REQ_W  = 2;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]        req_type;
      logic signed [VAL_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [STAT_W-1:0] status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_DONE
   } stfd_state_type;

endpackage

// File: src/stfd_table.sv
module stfd_table import stfd_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_addr,
   input  logic signed [VAL_W-1:0] wr_data,
   input  logic [IDX_W-1:0]        rd_addr,
   output logic signed [VAL_W-1:0] rd_data
);

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/stfd_ctrl.sv
module stfd_ctrl import stfd_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_word_type            req_data,
   output logic                    res_valid,
   input  logic                    res_ready,
   output rsp_word_type            res_data,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_addr,
   output logic signed [VAL_W-1:0] wr_data,
   output logic [IDX_W-1:0]        rd_addr,
   input  logic signed [VAL_W-1:0] rd_data
);

   localparam int POS_CW = (CNT_W > POS_W) ? CNT_W : POS_W;

   stfd_state_type          state_ff, state_in;
   logic [REQ_W-1:0]        op_ff, op_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        jdx_ff, jdx_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [STAT_W-1:0]       stat_ff, stat_in;

   logic                    val_gt;
   logic                    val_eq;
   logic [POS_CW-1:0]       pos_calc;
   logic [CNT_W-1:0]        idx_inc;
   logic [CNT_W-1:0]        jdx_dec;
   logic [CNT_W-1:0]        jdx_inc;

   // shared compare unit: request value against the entry just read
   assign val_gt = val_ff > rd_data;
   assign val_eq = val_ff == rd_data;

   assign pos_calc = POS_CW'(idx_ff) + POS_CW'(1);
   assign idx_inc  = idx_ff + CNT_W'(1);
   assign jdx_dec  = jdx_ff - CNT_W'(1);
   assign jdx_inc  = jdx_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      jdx_ff  <= jdx_in;
      pos_ff  <= pos_in;
      stat_ff <= stat_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      jdx_in    = jdx_ff;
      pos_in    = pos_ff;
      stat_in   = stat_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[IDX_W-1:0];
      wr_data   = val_ff;
      rd_addr   = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in   = req_data.req_type;
               val_in  = req_data.value;
               idx_in  = '0;
               pos_in  = '0;
               stat_in = STAT_OK;
               if (req_data.req_type == REQ_INSERT && cnt_ff == CNT_W'(CAPACITY)) begin
                  stat_in  = STAT_FULL;
                  state_in = S_DONE;
               end else if (req_data.req_type == REQ_INSERT ||
                            req_data.req_type == REQ_FIND ||
                            req_data.req_type == REQ_DELETE) begin
                  state_in = S_SCAN_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_SCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               // ran off the end: insert appends, find and delete miss
               if (op_ff == REQ_INSERT) begin
                  state_in = S_PLACE;
               end else begin
                  stat_in  = STAT_MISS;
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_SCAN_CMP;
            end
         end

         S_SCAN_CMP: begin
            if (op_ff == REQ_INSERT) begin
               if (val_gt) begin
                  idx_in   = idx_inc;
                  state_in = S_SCAN_RD;
               end else begin
                  jdx_in   = cnt_ff;
                  state_in = S_SHIFT_RD;
               end
            end else if (val_eq) begin
               if (op_ff == REQ_FIND) begin
                  pos_in   = pos_calc[POS_W-1:0];
                  state_in = S_DONE;
               end else if (idx_inc < cnt_ff) begin
                  jdx_in   = idx_ff;
                  state_in = S_SHIFT_RD;
               end else begin
                  cnt_in   = cnt_ff - CNT_W'(1);
                  pos_in   = pos_calc[POS_W-1:0];
                  state_in = S_DONE;
               end
            end else begin
               idx_in   = idx_inc;
               state_in = S_SCAN_RD;
            end
         end

         S_SHIFT_RD: begin
            // insert moves entries up from the tail, delete pulls them down
            if (op_ff == REQ_INSERT) begin
               rd_addr = jdx_dec[IDX_W-1:0];
            end else begin
               rd_addr = jdx_inc[IDX_W-1:0];
            end
            state_in = S_SHIFT_WR;
         end

         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = jdx_ff[IDX_W-1:0];
            wr_data = rd_data;
            if (op_ff == REQ_INSERT) begin
               jdx_in = jdx_dec;
               if (jdx_dec > idx_ff) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               jdx_in = jdx_inc;
               if (jdx_inc + CNT_W'(1) < cnt_ff) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  cnt_in   = cnt_ff - CNT_W'(1);
                  pos_in   = pos_calc[POS_W-1:0];
                  state_in = S_DONE;
               end
            end
         end

         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0];
            wr_data  = val_ff;
            cnt_in   = cnt_ff + CNT_W'(1);
            pos_in   = pos_calc[POS_W-1:0];
            state_in = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_data.position = pos_ff;
   assign res_data.status   = stat_ff;

endmodule

// File: src/sorted_table_insert_find_delete_core.sv
// Sorted table of signed 32-bit values with insert, find and delete.
// Request channel (req_valid/req_ready/req_data) carries one word: an
// operation code and a value. Response channel (rsp_valid/rsp_ready/
// rsp_data) returns exactly one word per request: 1-based position and
// a status (ok, not found, table full). Unused operation codes return
// position 0 with status ok and leave the table alone.
// One request is in flight at a time. A single compare unit walks the
// table one entry at a time (read, then compare), and entries are
// moved one at a time, read and then written, through the table's
// read and write ports.
// Reset empties the table; stored values are not cleared and are never
// read before they are written.
// The response sits in an output register; the next request is taken
// while it waits. A stalled receiver holds the following response in
// the sequencer, which then accepts nothing until the output drains.
module sorted_table_insert_find_delete_core import stfd_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic signed [VAL_W-1:0] wr_data;
   logic [IDX_W-1:0]        rd_addr;
   logic signed [VAL_W-1:0] rd_data;

   logic                    res_valid;
   logic                    res_ready;
   rsp_word_type            res_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_data_ff, rsp_data_in;

   stfd_table #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stfd_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // output register: load when empty or draining this cycle
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: bench/tb_sorted_table_insert_find_delete_core.sv
module tb_sorted_table_insert_find_delete_core;
   import stfd_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 520;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct {
      req_word_type word;
      bit           fixed;
      rsp_word_type rsp;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   // shadow copy of the sorted table
   logic signed [VAL_W-1:0] table_vals [TABLE_DEPTH];
   int unsigned             table_len = 0;

   rsp_word_type expected_rsp [$];
   dir_row_type  dir_rows [$];
   rsp_word_type rsp_want;

   int unsigned errors = 0;
   int unsigned rsp_seen = 0;
   int unsigned n_insert = 0;
   int unsigned n_find = 0;
   int unsigned n_delete = 0;
   int unsigned n_unused = 0;
   int unsigned n_full = 0;
   int unsigned n_miss = 0;
   int unsigned max_len = 0;

   bit          steady = 1'b0;
   int unsigned hold_off_asks = 0;
   int unsigned hold_off_seen = 0;
   int unsigned hold_left = 0;

   sorted_table_insert_find_delete_core #(
      .CAPACITY(TABLE_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      #5000000;
      $display("FAIL sorted_table_insert_find_delete_core");
      $finish;
   end

   // apply one request to the shadow table and return its response word
   function automatic rsp_word_type table_apply(input req_word_type w);
      rsp_word_type            r;
      logic signed [VAL_W-1:0] v;
      int                      hit;
      int                      slot;
      v = w.value;
      r.position = '0;
      r.status = STAT_OK;
      hit = -1;
      for (int i = 0; i < table_len; i++)
         if (hit < 0 && table_vals[i] == v) hit = i;
      case (w.req_type)
         REQ_INSERT: begin
            n_insert++;
            if (table_len >= TABLE_DEPTH) begin
               r.status = STAT_FULL;
               n_full++;
            end else begin
               slot = 0;
               while (slot < table_len && v > table_vals[slot]) slot++;
               for (int i = table_len; i > slot; i--) table_vals[i] = table_vals[i-1];
               table_vals[slot] = v;
               table_len++;
               r.position = POS_W'(slot + 1);
            end
         end
         REQ_FIND: begin
            n_find++;
            if (hit >= 0) begin
               r.position = POS_W'(hit + 1);
            end else begin
               r.status = STAT_MISS;
               n_miss++;
            end
         end
         REQ_DELETE: begin
            n_delete++;
            if (hit >= 0) begin
               for (int i = hit; i + 1 < table_len; i++) table_vals[i] = table_vals[i+1];
               table_len--;
               r.position = POS_W'(hit + 1);
            end else begin
               r.status = STAT_MISS;
               n_miss++;
            end
         end
         default: n_unused++;
      endcase
      if (table_len > max_len) max_len = table_len;
      return r;
   endfunction

   function automatic void add_row(input logic [REQ_W-1:0] op, input logic [VAL_W-1:0] val,
                                   input bit fixed, input int pos,
                                   input logic [STAT_W-1:0] stat);
      dir_row_type row;
      row.word.req_type = op;
      row.word.value = val;
      row.fixed = fixed;
      row.rsp.position = POS_W'(pos);
      row.rsp.status = stat;
      dir_rows.push_back(row);
   endfunction

   // operands lean on values already stored so finds and deletes hit
   function automatic req_word_type pick_word(input int unsigned insert_pct,
                                              input int unsigned delete_pct);
      req_word_type w;
      int unsigned  r;
      r = $urandom_range(0, 99);
      if (r < insert_pct) w.req_type = REQ_INSERT;
      else if (r < insert_pct + delete_pct) w.req_type = REQ_DELETE;
      else w.req_type = REQ_FIND;
      r = $urandom_range(0, 99);
      if (r < 55 && table_len != 0) begin
         w.value = table_vals[$urandom_range(0, table_len - 1)];
      end else if (r < 80) begin
         w.value = $urandom_range(0, 16) - 8;
      end else if (r < 95) begin
         w.value = $urandom();
      end else begin
         case ($urandom_range(0, 3))
            0: w.value = 32'h8000_0000;
            1: w.value = 32'h7FFF_FFFF;
            2: w.value = '0;
            default: w.value = '1;
         endcase
      end
      return w;
   endfunction

   // offer one word, hold it until accepted, then record its response
   task automatic send_word(input req_word_type w, input bit fixed, input rsp_word_type fixed_rsp);
      int unsigned  gap;
      rsp_word_type got;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = table_apply(w);
      expected_rsp.push_back(fixed ? fixed_rsp : got);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned words, input int unsigned insert_pct,
                               input int unsigned delete_pct);
      req_word_type w;
      int unsigned  sent;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 99) < 3) begin
            w.req_type = REQ_UNUSED;
            w.value = $urandom();
         end else begin
            w = pick_word(insert_pct, delete_pct);
            sent++;
         end
         send_word(w, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected response word: position=%0d status=%0d",
                      rsp_data.position, rsp_data.status);
               errors++;
            end else begin
               rsp_want = expected_rsp.pop_front();
               rsp_seen++;
               if (rsp_data.position !== rsp_want.position) begin
                  $error("position: expected %0d, actual %0d", rsp_want.position,
                         rsp_data.position);
                  errors++;
               end
               if (rsp_data.status !== rsp_want.status) begin
                  $error("status: expected %0d, actual %0d", rsp_want.status,
                         rsp_data.status);
                  errors++;
               end
            end
         end
         if (hold_off_asks != hold_off_seen) begin
            hold_off_seen = hold_off_asks;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
         end
      end
   end

   initial begin
      int unsigned guard;

      // empty table first, then the lone-entry delete, then fill to full
      add_row(REQ_FIND,   32'd0,        1, 0, STAT_MISS);
      add_row(REQ_DELETE, 32'd5,        1, 0, STAT_MISS);
      add_row(REQ_UNUSED, 32'hFFFF_FFFF, 1, 0, STAT_OK);
      add_row(REQ_INSERT, 32'd42,       1, 1, STAT_OK);
      add_row(REQ_DELETE, 32'd42,       1, 1, STAT_OK);
      add_row(REQ_FIND,   32'd42,       1, 0, STAT_MISS);
      add_row(REQ_INSERT, 32'h7FFF_FFFF, 1, 1, STAT_OK);
      add_row(REQ_INSERT, 32'h8000_0000, 1, 1, STAT_OK);
      add_row(REQ_INSERT, 32'h7FFF_FFFF, 0, 0, STAT_OK);
      add_row(REQ_FIND,   32'h7FFF_FFFF, 0, 0, STAT_OK);
      add_row(REQ_FIND,   32'h8000_0000, 1, 1, STAT_OK);
      add_row(REQ_INSERT, 32'd0,        0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'hFFFF_FFFF, 0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'd1,        0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'd100,      0, 0, STAT_OK);
      add_row(REQ_INSERT, -32'sd100,    0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'd7,        0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'd7,        0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'h4000_0000, 0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'h8000_0001, 0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'h7FFF_FFFE, 0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'd3,        0, 0, STAT_OK);
      add_row(REQ_INSERT, -32'sd3,      0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'h5555_AAAA, 0, 0, STAT_OK);
      add_row(REQ_INSERT, 32'd5,        1, 0, STAT_FULL);
      add_row(REQ_DELETE, 32'h7FFF_FFFF, 0, 0, STAT_OK);
      add_row(REQ_DELETE, 32'h8000_0000, 1, 1, STAT_OK);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      steady = 1'b0;
      foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].rsp);

      // no idling on either side
      steady = 1'b1;
      random_phase(120, 50, 25);

      // stall the receiver long enough to back up the input
      steady = 1'b0;
      hold_off_asks++;
      random_phase(150, 50, 25);

      wait_drained();
      random_phase(100, 20, 60);
      random_phase(RANDOM_WORDS - 370, 50, 25);

      req_valid <= 1'b0;
      guard = 0;
      while (expected_rsp.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d response words never arrived", expected_rsp.size());
         errors++;
      end

      $display("Ran %0d inserts, %0d finds, %0d deletes, %0d unused codes; %0d words checked.",
               n_insert, n_find, n_delete, n_unused, rsp_seen);
      $display("Saw %0d full-table refusals, %0d misses, peak table size %0d.",
               n_full, n_miss, max_len);
      if (errors == 0) begin
         $display("PASS sorted_table_insert_find_delete_core");
      end else begin
         $display("FAIL sorted_table_insert_find_delete_core");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/stfd_pkg.sv
src/stfd_table.sv
src/stfd_ctrl.sv
src/sorted_table_insert_find_delete_core.sv
bench/tb_sorted_table_insert_find_delete_core.sv
